### hw/rtl/tmh_pkg.sv
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants of the timer min-heap: request and response
// structs, heap entry layout, command codes and engine status.
// ----------------------------------------------------------------------------
package tmh_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 48;
    localparam int HANDLE_W = 16;
    localparam int DELAY_W  = 24;

    // request command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                command;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
    } t_req;

    typedef struct packed {
        logic                fired;
        logic [HANDLE_W-1:0] fired_handle;
        logic                push_rejected;
        logic [CNT_W-1:0]    pending_count;
    } t_rsp;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

### hw/rtl/tmh_ram.sv
// ----------------------------------------------------------------------------
// tmh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tmh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/tmh_engine.sv
// ----------------------------------------------------------------------------
// tmh_engine
// Heap sequencer: keeps time and entry count, walks the heap memory one
// level per cycle for sift-up on push and sift-down after a pop on tick.
// ----------------------------------------------------------------------------
module tmh_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tmh_pkg::t_req      i_req,
    input  logic               i_take,
    output tmh_pkg::t_eng_stat o_stat,
    output tmh_pkg::t_rsp      o_rsp
);
    import tmh_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_UP    = 6'b000010,
        ST_TICK  = 6'b000100,
        ST_DOWN  = 6'b001000,
        ST_PLACE = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    t_entry            r_ent, n_ent;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0] r_now, n_now;
    t_rsp              r_res, n_res;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    logic [IDX_W-1:0]  w_raddr_a;
    logic [IDX_W-1:0]  w_raddr_b;
    t_entry            w_rd_a;
    t_entry            w_rd_b;

    logic [IDX_W-1:0]  w_par;
    logic [IDX_W-1:0]  w_gpar;
    logic [IDX_W-1:0]  w_left;
    logic [IDX_W-1:0]  w_right;
    logic              w_take_r;
    t_entry            w_child;
    logic [IDX_W-1:0]  w_cidx;
    logic [CNT_W-1:0]  w_half;
    logic [CNT_W-1:0]  w_cnt_dec;

    tmh_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr_a(w_raddr_a),
        .i_raddr_b(w_raddr_b),
        .o_rdata_a(w_rd_a),
        .o_rdata_b(w_rd_b)
    );

    // heap index arithmetic
    assign w_par     = (r_pos - IDX_W'(1)) >> 1;
    assign w_gpar    = (w_par - IDX_W'(1)) >> 1;
    assign w_left    = {r_pos[IDX_W-2:0], 1'b1};
    assign w_right   = w_left + IDX_W'(1);
    assign w_half    = r_count >> 1;
    assign w_cnt_dec = r_count - CNT_W'(1);

    // pick the smaller child, left on a tie
    assign w_take_r = (CNT_W'(w_right) < r_count) && (w_rd_a.deadline > w_rd_b.deadline);
    assign w_child  = w_take_r ? w_rd_b : w_rd_a;
    assign w_cidx   = w_take_r ? w_right : w_left;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_ent     = r_ent;
        n_count   = r_count;
        n_now     = r_now;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_ent;
        w_raddr_a = '0;
        w_raddr_b = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_res = '0;
                    if (i_req.command == CMD_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res.push_rejected = 1'b1;
                            n_res.pending_count = r_count;
                            n_state             = ST_DONE;
                        end else begin
                            n_ent.deadline      = r_now + TIME_W'(i_req.delay);
                            n_ent.handle        = i_req.handle;
                            n_pos               = r_count[IDX_W-1:0];
                            n_count             = r_count + CNT_W'(1);
                            n_res.pending_count = r_count + CNT_W'(1);
                            if (r_count == '0) begin
                                n_state = ST_PLACE;
                            end else begin
                                w_raddr_a = (r_count[IDX_W-1:0] - IDX_W'(1)) >> 1;
                                n_state   = ST_UP;
                            end
                        end
                    end else begin
                        // advance time, fetch root and last entry
                        n_now               = r_now + TIME_W'(1);
                        n_res.pending_count = r_count;
                        w_raddr_a           = '0;
                        w_raddr_b           = r_count[IDX_W-1:0] - IDX_W'(1);
                        n_state             = ST_TICK;
                    end
                end
            end

            ST_UP: begin
                // move a strictly later parent down into the hole
                w_we = 1'b1;
                if (w_rd_a.deadline > r_ent.deadline) begin
                    w_wdata = w_rd_a;
                    n_pos   = w_par;
                    if (w_par == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        w_raddr_a = w_gpar;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_TICK: begin
                if ((r_count != '0) && (w_rd_a.deadline <= r_now)) begin
                    n_res.fired         = 1'b1;
                    n_res.fired_handle  = w_rd_a.handle;
                    n_res.pending_count = w_cnt_dec;
                    n_count             = w_cnt_dec;
                    n_ent               = w_rd_b;
                    n_pos               = '0;
                    if ((w_cnt_dec >> 1) != '0) begin
                        w_raddr_a = IDX_W'(1);
                        w_raddr_b = IDX_W'(2);
                        n_state   = ST_DOWN;
                    end else begin
                        n_state = ST_PLACE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_DOWN: begin
                // lift the smaller child unless it is strictly later
                w_we = 1'b1;
                if (w_child.deadline > r_ent.deadline) begin
                    n_state = ST_DONE;
                end else begin
                    w_wdata = w_child;
                    n_pos   = w_cidx;
                    if (CNT_W'(w_cidx) < w_half) begin
                        w_raddr_a = {w_cidx[IDX_W-2:0], 1'b1};
                        w_raddr_b = {w_cidx[IDX_W-2:0], 1'b1} + IDX_W'(1);
                    end else begin
                        n_state = ST_PLACE;
                    end
                end
            end

            ST_PLACE: begin
                w_we    = 1'b1;
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_now   <= n_now;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_ent <= n_ent;
        r_res <= n_res;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_rsp       = r_res;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !w_we)
        else $error("heap write outside a sift");

    a_start_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> r_state != ST_IDLE)
        else $error("accepted request did not start");

    a_rsp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !(r_res.fired && r_res.push_rejected))
        else $error("response both fired and rejected");

endmodule

### hw/rtl/timer_min_heap.sv
// ----------------------------------------------------------------------------
// timer_min_heap
// Timer queue as a binary min-heap of deadlines in one heap memory.
// Push inserts now + delay with a handle; tick advances time and pops one due entry.
// ----------------------------------------------------------------------------
// Sequence: a push sifts the new entry up from the end of the heap; a tick
// pops a due root and sifts the last entry down; the response register then
// holds the result. Throughput: one request at a time, accepted only when idle.
// Reset: clears time, entry count and control; heap memory holds no reset value.
// ----------------------------------------------------------------------------
module timer_min_heap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  tmh_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output tmh_pkg::t_rsp  o_rsp
);
    import tmh_pkg::*;

    t_eng_stat w_stat;
    t_rsp      w_eng_rsp;
    logic      w_start;
    logic      w_take;
    logic      r_rsp_valid;
    t_rsp      r_rsp;

    // accept a request whenever the engine is idle
    assign o_req_ready = w_stat.idle;
    assign w_start     = i_req_valid && w_stat.idle;

    // move a finished result into the response register when it is free
    assign w_take = w_stat.done && (!r_rsp_valid || i_rsp_ready);

    tmh_engine u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_req  (i_req),
        .i_take (w_take),
        .o_stat (w_stat),
        .o_rsp  (w_eng_rsp)
    );

    // hold response valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_take) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= w_eng_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
